// ----- rtl/rmha_pkg.sv -----
// Shared types and constants for the register map hash allocator.
// Holds slot state codes, result status codes, port widths and the key hash.
// No dependencies.
package rmha_pkg;

   // result field widths, fixed by the interface
   localparam int PHYS_W   = 3;
   localparam int STATUS_W = 2;

   // slot state codes
   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_USED  = 2'd1;
   localparam logic [1:0] SLOT_TOMB  = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] RSP_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] RSP_NO_FREE = 2'd1;
   localparam logic [STATUS_W-1:0] RSP_FULL    = 2'd2;

   // item modes
   localparam logic MODE_MAP     = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   // 32-bit xorshift: << 13, >> 17, << 5
   function automatic logic [31:0] mix32(input logic [31:0] a);
      logic [31:0] b;
      logic [31:0] c;
      b = a ^ (a << 13);
      c = b ^ (b >> 17);
      return c ^ (c << 5);
   endfunction

endpackage

// ----- rtl/rmha_front.sv -----
// Front end: accepts items, hashes the key to a home slot, queues them.
// Uses rmha_pkg (mix32). Feeds rmha_back through a two-entry queue.
module rmha_front
   import rmha_pkg::*;
#(
   parameter int KEY_BITS = 16,
   parameter int IDX_W    = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  logic                in_mode,
   input  logic [KEY_BITS-1:0] in_key,
   input  logic                pop,
   output logic                q_valid,
   output logic                q_mode,
   output logic [KEY_BITS-1:0] q_key,
   output logic [IDX_W-1:0]    q_idx
);

   localparam int DEPTH = 2;

   logic                mode_mem [DEPTH];
   logic [KEY_BITS-1:0] key_mem  [DEPTH];
   logic [IDX_W-1:0]    idx_mem  [DEPTH];

   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;
   logic [31:0] hash;

   assign hash    = mix32(32'(in_key));
   assign full    = (count_ff == 2'(DEPTH));
   assign q_valid = (count_ff != 2'd0);
   assign q_mode  = mode_mem[rd_ptr_ff];
   assign q_key   = key_mem[rd_ptr_ff];
   assign q_idx   = idx_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mode_mem[wr_ptr_ff] <= in_mode;
         key_mem[wr_ptr_ff]  <= in_key;
         idx_mem[wr_ptr_ff]  <= hash[IDX_W-1:0];
      end
   end

endmodule

// ----- rtl/rmha_back.sv -----
// Back end: linear probe of the slot table, register pool and result register.
// Uses rmha_pkg codes. Takes queued items from rmha_front.
module rmha_back
   import rmha_pkg::*;
#(
   parameter int TABLE_SLOTS = 16,
   parameter int POOL_REGS   = 7,
   parameter int KEY_BITS    = 16,
   parameter int IDX_W       = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  logic                q_mode,
   input  logic [KEY_BITS-1:0] q_key,
   input  logic [IDX_W-1:0]    q_idx,
   output logic                pop,
   output logic                rsp_valid,
   output logic [PHYS_W-1:0]   rsp_phys_reg,
   output logic                rsp_found,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int REG_W = (POOL_REGS > 1) ? $clog2(POOL_REGS) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_PROBE = 2'd1;
   localparam logic [1:0] S_DONE  = 2'd2;

   // slot table: state in resettable flops, key and register in memories
   logic [1:0]          slot_state_ff [TABLE_SLOTS];
   logic [KEY_BITS-1:0] key_mem [TABLE_SLOTS];
   logic [REG_W-1:0]    reg_mem [TABLE_SLOTS];

   logic [1:0]          rd_st_ff;
   logic [KEY_BITS-1:0] rd_key_ff;
   logic [REG_W-1:0]    rd_reg_ff;
   logic [IDX_W-1:0]    rd_addr;

   logic [1:0]           state_ff,  state_in;
   logic                 mode_ff,   mode_in;
   logic [KEY_BITS-1:0]  key_ff,    key_in;
   logic [IDX_W-1:0]     cur_ff,    cur_in;
   logic [IDX_W-1:0]     cnt_ff,    cnt_in;
   logic [IDX_W-1:0]     tomb_ff,   tomb_in;
   logic                 tomb_v_ff, tomb_v_in;
   logic                 hit_ff,    hit_in;
   logic [IDX_W-1:0]     slot_ff,   slot_in;
   logic                 slot_ok_ff, slot_ok_in;
   logic [REG_W-1:0]     hreg_ff,   hreg_in;
   logic [POOL_REGS-1:0] pool_ff,   pool_in;

   logic                rsp_valid_ff,  rsp_valid_in;
   logic [PHYS_W-1:0]   rsp_phys_ff,   rsp_phys_in;
   logic                rsp_found_ff,  rsp_found_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   // probe decode
   logic             is_used, is_tomb, is_empty, match, last;
   logic             tomb_v_new;
   logic [IDX_W-1:0] tomb_new;

   // write-back controls
   logic             free_ok;
   logic [REG_W-1:0] free_reg;
   logic             tab_we;
   logic             st_we;
   logic [1:0]       st_wdata;

   assign pop     = (state_ff == S_IDLE) && q_valid;
   assign rd_addr = (state_ff == S_IDLE) ? q_idx : IDX_W'(cur_ff + 1'b1);

   assign is_used    = (rd_st_ff == SLOT_USED);
   assign is_tomb    = (rd_st_ff == SLOT_TOMB);
   assign is_empty   = !is_used && !is_tomb;
   assign match      = is_used && (rd_key_ff == key_ff);
   assign last       = (cnt_ff == IDX_W'(TABLE_SLOTS - 1));
   assign tomb_v_new = tomb_v_ff | is_tomb;
   assign tomb_new   = tomb_v_ff ? tomb_ff : cur_ff;

   // lowest free pool register
   always_comb begin
      free_ok  = 1'b0;
      free_reg = '0;
      for (int r = POOL_REGS - 1; r >= 0; r--) begin
         if (!pool_ff[r]) begin
            free_ok  = 1'b1;
            free_reg = REG_W'(r);
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      tomb_in       = tomb_ff;
      tomb_v_in     = tomb_v_ff;
      hit_in        = hit_ff;
      slot_in       = slot_ff;
      slot_ok_in    = slot_ok_ff;
      hreg_in       = hreg_ff;
      pool_in       = pool_ff;
      rsp_valid_in  = 1'b0;
      rsp_phys_in   = '0;
      rsp_found_in  = 1'b0;
      rsp_status_in = RSP_OK;
      tab_we        = 1'b0;
      st_we         = 1'b0;
      st_wdata      = SLOT_EMPTY;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               mode_in   = q_mode;
               key_in    = q_key;
               cur_in    = q_idx;
               cnt_in    = '0;
               tomb_v_in = 1'b0;
               state_in  = S_PROBE;
            end
         end
         S_PROBE: begin
            if (match) begin
               hit_in   = 1'b1;
               slot_in  = cur_ff;
               hreg_in  = rd_reg_ff;
               state_in = S_DONE;
            end else if (is_empty) begin
               hit_in     = 1'b0;
               slot_in    = tomb_new;
               slot_ok_in = 1'b1;
               state_in   = S_DONE;
            end else if (last) begin
               hit_in     = 1'b0;
               slot_in    = tomb_new;
               slot_ok_in = tomb_v_new;
               state_in   = S_DONE;
            end else begin
               cur_in    = IDX_W'(cur_ff + 1'b1);
               cnt_in    = IDX_W'(cnt_ff + 1'b1);
               tomb_in   = tomb_new;
               tomb_v_in = tomb_v_new;
            end
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (mode_ff == MODE_MAP) begin
               if (hit_ff) begin
                  rsp_phys_in  = PHYS_W'(hreg_ff);
                  rsp_found_in = 1'b1;
               end else if (!free_ok) begin
                  rsp_status_in = RSP_NO_FREE;
               end else if (!slot_ok_ff) begin
                  rsp_status_in = RSP_FULL;
               end else begin
                  rsp_phys_in = PHYS_W'(free_reg);
                  tab_we      = 1'b1;
                  st_we       = 1'b1;
                  st_wdata    = SLOT_USED;
                  for (int r = 0; r < POOL_REGS; r++) begin
                     if (free_reg == REG_W'(r)) pool_in[r] = 1'b1;
                  end
               end
            end else if (hit_ff) begin
               rsp_phys_in  = PHYS_W'(hreg_ff);
               rsp_found_in = 1'b1;
               st_we        = 1'b1;
               st_wdata     = SLOT_TOMB;
               // registers beyond the pool match no bit and free nothing
               for (int r = 0; r < POOL_REGS; r++) begin
                  if (hreg_ff == REG_W'(r)) pool_in[r] = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pool_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      tomb_ff       <= tomb_in;
      tomb_v_ff     <= tomb_v_in;
      hit_ff        <= hit_in;
      slot_ff       <= slot_in;
      slot_ok_ff    <= slot_ok_in;
      hreg_ff       <= hreg_in;
      rsp_phys_ff   <= rsp_phys_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_status_ff <= rsp_status_in;
   end

   // slot states: one resettable entry per slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++) begin
            slot_state_ff[i] <= SLOT_EMPTY;
         end
      end else if (st_we) begin
         slot_state_ff[slot_ff] <= st_wdata;
      end
   end

   // slot key and register memories, registered read
   always_ff @(posedge clock) begin
      if (tab_we) begin
         key_mem[slot_ff] <= key_ff;
         reg_mem[slot_ff] <= free_reg;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_reg_ff <= reg_mem[rd_addr];
      rd_st_ff  <= slot_state_ff[rd_addr];
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_phys_reg = rsp_phys_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

// ----- rtl/register_map_hash_allocator_unit.sv -----
// Top level of the register map hash allocator.
// Depends on rmha_pkg, rmha_front and rmha_back.
//
// Usage:
//  - Request: drive req_mode / req_key and raise start. The item is taken at
//    a rising edge with start high and busy low. req_mode 0 looks up the key
//    and allocates a scratch register on a miss; req_mode 1 releases it.
//  - Response: rsp_valid pulses for one cycle with rsp_phys_reg, rsp_found
//    and rsp_status (ok / no free register / table full). The receiver must
//    take it in that cycle; there is no stall on the response side.
//  - Front: hashes the key (32-bit xorshift, masked to the slot count) and
//    holds up to two items in a queue; busy is high only when it is full.
//  - Back: probes one slot per cycle through the slot memories, stopping at
//    a key match, an empty slot or after TABLE_SLOTS slots, then writes back.
//  - Flow: an accepted item waits in the queue, is popped in S_IDLE, probes in
//    S_PROBE and has its response registered out of S_DONE.
//  - The single probe engine works on one item at a time; the queue takes new
//    items while it probes.
//  - Reset: synchronous; all slots empty, all pool registers free, queue
//    empty. Items may be sent in the cycle after reset drops.
module register_map_hash_allocator_unit
   import rmha_pkg::*;
#(
   parameter int TABLE_SLOTS = 16,
   parameter int POOL_REGS   = 7,
   parameter int KEY_BITS    = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_mode,
   input  logic [KEY_BITS-1:0] req_key,
   output logic                rsp_valid,
   output logic [PHYS_W-1:0]   rsp_phys_reg,
   output logic                rsp_found,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam int IDX_W = $clog2(TABLE_SLOTS);

   logic                push;
   logic                q_full;
   logic                q_valid;
   logic                q_pop;
   logic                q_mode;
   logic [KEY_BITS-1:0] q_key;
   logic [IDX_W-1:0]    q_idx;

   // accept whenever the queue has room
   assign busy = q_full;
   assign push = start && !q_full;

   rmha_front #(
      .KEY_BITS (KEY_BITS),
      .IDX_W    (IDX_W)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .full    (q_full),
      .in_mode (req_mode),
      .in_key  (req_key),
      .pop     (q_pop),
      .q_valid (q_valid),
      .q_mode  (q_mode),
      .q_key   (q_key),
      .q_idx   (q_idx)
   );

   rmha_back #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .POOL_REGS   (POOL_REGS),
      .KEY_BITS    (KEY_BITS),
      .IDX_W       (IDX_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_mode       (q_mode),
      .q_key        (q_key),
      .q_idx        (q_idx),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_phys_reg (rsp_phys_reg),
      .rsp_found    (rsp_found),
      .rsp_status   (rsp_status)
   );

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for register_map_hash_allocator_unit.
// It drives map and release items and checks each one against a predictor of the hash table
// and the register pool. Depends on rmha_pkg and the RTL top level.
module testbench
   import rmha_pkg::*;
();

   localparam int TABLE_SLOTS = 16;
   localparam int POOL_REGS   = 7;
   localparam int KEY_BITS    = 16;
   localparam int PLAN_ROWS   = 25;
   localparam int RANDOM_ITEMS = 1150;
   localparam int HOT_KEYS    = 12;

   // one response as the block reports it
   typedef struct packed {
      logic [PHYS_W-1:0]   phys;
      logic                found;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   // directed stimulus row; typed rows carry their answer, the rest use the predictor
   typedef struct packed {
      logic                mode;
      logic [KEY_BITS-1:0] key;
      logic                typed;
      rsp_type             want;
   } plan_row_type;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_mode;
   logic [KEY_BITS-1:0] req_key;
   logic                rsp_valid;
   logic [PHYS_W-1:0]   rsp_phys_reg;
   logic                rsp_found;
   logic [STATUS_W-1:0] rsp_status;

   // predictor state: slot table and pool occupancy
   logic [1:0]          slot_state [TABLE_SLOTS];
   logic [KEY_BITS-1:0] slot_key   [TABLE_SLOTS];
   logic [PHYS_W-1:0]   slot_reg   [TABLE_SLOTS];
   logic [POOL_REGS-1:0] reg_taken;

   rsp_type      pending_mappings [$];
   plan_row_type plan [PLAN_ROWS];
   logic [KEY_BITS-1:0] hot_keys [HOT_KEYS];
   int        plan_fill;
   int        mismatch_count;
   int        burst_left;

   register_map_hash_allocator_unit #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .POOL_REGS   (POOL_REGS),
      .KEY_BITS    (KEY_BITS)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_mode     (req_mode),
      .req_key      (req_key),
      .rsp_valid    (rsp_valid),
      .rsp_phys_reg (rsp_phys_reg),
      .rsp_found    (rsp_found),
      .rsp_status   (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop: well above the slowest legal run (every item a full 16-slot probe plus gaps)
   initial begin
      #4000000;
      $display("testbench: errors");
      $finish;
   end

   // home slot: xorshift of the key, low bits select the slot
   function automatic int home_slot(input logic [KEY_BITS-1:0] key);
      logic [31:0] h;
      h = 32'(key);
      h = h ^ {h[18:0], 13'b0};
      h = h ^ {17'b0, h[31:17]};
      h = h ^ {h[26:0], 5'b0};
      return int'(h) & (TABLE_SLOTS - 1);
   endfunction

   // probes the table as the block does and applies the map or release
   function automatic rsp_type resolve_mapping(input logic mode,
                                               input logic [KEY_BITS-1:0] key);
      rsp_type r;
      int   idx;
      int   tomb;
      int   spot;
      bit   hit;
      bit   done;
      int   free_reg;
      r = '0;
      idx = home_slot(key);
      tomb = -1;
      spot = -1;
      hit = 1'b0;
      done = 1'b0;
      free_reg = -1;
      for (int n = 0; n < TABLE_SLOTS && !done; n++) begin
         case (slot_state[idx])
            SLOT_USED: begin
               if (slot_key[idx] == key) begin
                  hit = 1'b1;
                  spot = idx;
                  done = 1'b1;
               end
            end
            SLOT_TOMB: begin
               if (tomb < 0) tomb = idx;
            end
            default: begin
               // empty slot ends the probe; an earlier tombstone wins
               spot = (tomb >= 0) ? tomb : idx;
               done = 1'b1;
            end
         endcase
         idx = (idx + 1) % TABLE_SLOTS;
      end
      if (!done) spot = tomb;

      if (mode == MODE_MAP) begin
         if (hit) begin
            r.phys = slot_reg[spot];
            r.found = 1'b1;
         end else begin
            for (int k = POOL_REGS - 1; k >= 0; k--)
               if (!reg_taken[k]) free_reg = k;
            // pool exhaustion is checked before a full table
            if (free_reg < 0) r.status = RSP_NO_FREE;
            else if (spot < 0) r.status = RSP_FULL;
            else begin
               reg_taken[free_reg] = 1'b1;
               slot_state[spot] = SLOT_USED;
               slot_key[spot] = key;
               slot_reg[spot] = free_reg[PHYS_W-1:0];
               r.phys = free_reg[PHYS_W-1:0];
            end
         end
      end else if (hit) begin
         r.phys = slot_reg[spot];
         r.found = 1'b1;
         slot_state[spot] = SLOT_TOMB;
         reg_taken[r.phys] = 1'b0;
      end
      return r;
   endfunction

   task automatic add_row(input logic mode, input logic [KEY_BITS-1:0] key, input logic typed,
                          input logic [PHYS_W-1:0] phys, input logic found,
                          input logic [STATUS_W-1:0] status);
      plan[plan_fill] = '{mode: mode, key: key, typed: typed,
                          want: '{phys: phys, found: found, status: status}};
      plan_fill++;
   endtask

   // drops start at the next falling edge and holds it low for the requested gap
   task automatic idle_cycles(input int n);
      if (n > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // presents one item and waits until the block takes it; the answer is queued on acceptance
   task automatic send_item(input logic mode, input logic [KEY_BITS-1:0] key,
                            input logic typed, input rsp_type want);
      rsp_type predicted;
      @(negedge clock);
      start <= 1'b1;
      req_mode <= mode;
      req_key <= key;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      predicted = resolve_mapping(mode, key);
      pending_mappings.push_back(typed ? want : predicted);
   endtask

   // mostly short gaps, a few long ones, and now and then a back-to-back burst
   function automatic int pick_gap();
      int roll;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         burst_left = $urandom_range(20, 40);
         return 0;
      end
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // response checker: every strobe must match the oldest queued answer
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_valid) begin
         got = '{phys: rsp_phys_reg, found: rsp_found, status: rsp_status};
         if (pending_mappings.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: phys %0d found %0d status %0d",
                        got.phys, got.found, got.status);
         end else begin
            want = pending_mappings.pop_front();
            if (got.phys !== want.phys || got.found !== want.found
                || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: exp phys %0d found %0d status %0d, got %0d %0d %0d",
                           want.phys, want.found, want.status,
                           got.phys, got.found, got.status);
            end
         end
      end
   end

   initial begin
      logic                mode;
      logic [KEY_BITS-1:0] key;
      int                  roll;
      int                  drain_wait;

      // all inputs known from time zero
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_MAP;
      req_key = '0;
      mismatch_count = 0;
      burst_left = 0;
      plan_fill = 0;
      reg_taken = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         slot_state[i] = SLOT_EMPTY;
         slot_key[i] = '0;
         slot_reg[i] = '0;
      end
      // small working set of keys so maps hit, releases find mappings, and tombstones pile up
      for (int i = 0; i < HOT_KEYS; i++) hot_keys[i] = KEY_BITS'($urandom);

      // directed plan: pool handouts are fixed by key order, so most answers are known
      add_row(MODE_MAP,     16'h0000, 1'b1, 3'd0, 1'b0, RSP_OK);      // first map, lowest reg
      add_row(MODE_MAP,     16'h0000, 1'b1, 3'd0, 1'b1, RSP_OK);      // hit
      add_row(MODE_MAP,     16'hFFFF, 1'b1, 3'd1, 1'b0, RSP_OK);      // max key
      add_row(MODE_RELEASE, 16'hFFFF, 1'b1, 3'd1, 1'b1, RSP_OK);      // release mapped
      add_row(MODE_RELEASE, 16'hFFFF, 1'b1, 3'd0, 1'b0, RSP_OK);      // release unmapped
      add_row(MODE_MAP,     16'h8000, 1'b1, 3'd1, 1'b0, RSP_OK);      // freed reg reused
      add_row(MODE_MAP,     16'h0001, 1'b1, 3'd2, 1'b0, RSP_OK);
      add_row(MODE_MAP,     16'h0002, 1'b1, 3'd3, 1'b0, RSP_OK);
      add_row(MODE_MAP,     16'h0003, 1'b1, 3'd4, 1'b0, RSP_OK);
      add_row(MODE_MAP,     16'h0004, 1'b1, 3'd5, 1'b0, RSP_OK);
      add_row(MODE_MAP,     16'h0005, 1'b1, 3'd6, 1'b0, RSP_OK);      // pool now exhausted
      add_row(MODE_MAP,     16'h0006, 1'b1, 3'd0, 1'b0, RSP_NO_FREE); // miss with no free reg
      add_row(MODE_MAP,     16'h8000, 1'b1, 3'd1, 1'b1, RSP_OK);      // hit still works when full
      add_row(MODE_RELEASE, 16'h0003, 1'b1, 3'd4, 1'b1, RSP_OK);
      add_row(MODE_MAP,     16'h0006, 1'b1, 3'd4, 1'b0, RSP_OK);
      add_row(MODE_RELEASE, 16'h0000, 1'b1, 3'd0, 1'b1, RSP_OK);
      add_row(MODE_RELEASE, 16'h5555, 1'b1, 3'd0, 1'b0, RSP_OK);
      add_row(MODE_MAP,     16'hAAAA, 1'b1, 3'd0, 1'b0, RSP_OK);
      add_row(MODE_RELEASE, 16'h8000, 1'b1, 3'd1, 1'b1, RSP_OK);
      add_row(MODE_MAP,     16'h8000, 1'b0, 3'd0, 1'b0, RSP_OK);      // may land on a tombstone
      add_row(MODE_RELEASE, 16'h0001, 1'b0, 3'd0, 1'b0, RSP_OK);
      add_row(MODE_RELEASE, 16'h0002, 1'b0, 3'd0, 1'b0, RSP_OK);
      add_row(MODE_RELEASE, 16'h0004, 1'b0, 3'd0, 1'b0, RSP_OK);
      add_row(MODE_RELEASE, 16'h0005, 1'b0, 3'd0, 1'b0, RSP_OK);
      add_row(MODE_RELEASE, 16'h0006, 1'b0, 3'd0, 1'b0, RSP_OK);

      // synchronous reset, then let go on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < PLAN_ROWS; i++) begin
         idle_cycles(pick_gap());
         send_item(plan[i].mode, plan[i].key, plan[i].typed, plan[i].want);
      end

      // random traffic: mostly the hot keys, some fully random keys and the extremes
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         mode = ($urandom_range(0, 99) < 55) ? MODE_MAP : MODE_RELEASE;
         roll = $urandom_range(0, 99);
         if (roll < 80) key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
         else if (roll < 95) key = KEY_BITS'($urandom);
         else key = $urandom_range(0, 1) ? '1 : '0;
         idle_cycles(pick_gap());
         send_item(mode, key, 1'b0, '0);
      end

      // drop start and let the queued items drain
      idle_cycles(1);
      drain_wait = 0;
      while (pending_mappings.size() != 0 && drain_wait < 2000) begin
         @(posedge clock);
         drain_wait++;
      end
      // wait on, to catch stray strobes
      repeat (60) @(posedge clock);

      if (mismatch_count == 0 && pending_mappings.size() == 0) begin
         $display("testbench: clean");
      end else begin
         if (pending_mappings.size() != 0)
            $display("%0d responses never arrived", pending_mappings.size());
         $display("testbench: errors");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/rmha_pkg.sv
rtl/rmha_front.sv
rtl/rmha_back.sv
rtl/register_map_hash_allocator_unit.sv
sim/testbench.sv
